### src/ipp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_pkg
// Types, character codes and byte-placement helpers for the address text
// parser.
// ----------------------------------------------------------------------------
package ipp_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam int unsigned NUM_BYTES = 16;
  localparam logic [4:0]  BYTES_END = 5'd16;
  localparam logic [4:0]  PAIR_LIMIT = 5'd14;
  localparam logic [4:0]  TAIL_LIMIT = 5'd12;
  localparam logic [2:0]  MAX_OCTETS = 3'd4;
  localparam logic [2:0]  MAX_DIGITS = 3'd4;
  localparam logic [15:0] GROUP_LIMIT = 16'h0fff;
  localparam logic [11:0] OCTET_MAX = 12'd255;
  localparam logic [9:0]  DEC_MAX = 10'd255;

  // Text position codes
  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_COLON = 2'd1;
  localparam logic [1:0] POS_BODY  = 2'd2;

  // Register indexes
  localparam logic REG_ADDRESS_FAMILY = 1'b0;

  typedef struct packed {
    logic [127:0] head;      // bytes placed before the gap, byte 0 on top
    logic [127:0] tail;      // bytes after the gap, shifted in from the bottom
    logic [4:0]   wp;
    logic [4:0]   gp;
    logic         gap_seen;
    logic [15:0]  gv;
    logic         ds;
    logic [2:0]   tdc;
    logic         letter;
    logic         in_tail;
    logic [7:0]   ov;
    logic [2:0]   oc;
    logic         err;
    logic [1:0]   cp;
    logic         cjcg;
  } ipp_state_t;

  function automatic logic [127:0] head_put(input logic [127:0] h, input logic [4:0] wp,
                                            input logic [1:0] n, input logic [7:0] b0,
                                            input logic [7:0] b1);
    logic [127:0] r;
    r = h;
    for (int i = 0; i < NUM_BYTES; i++) begin
      if (n != 2'd0 && wp == 5'(i)) r[127-8*i -: 8] = b0;
      if (n == 2'd2 && (wp + 5'd1) == 5'(i)) r[127-8*i -: 8] = b1;
    end
    return r;
  endfunction

  function automatic logic [127:0] tail_put(input logic [127:0] t, input logic [1:0] n,
                                            input logic [7:0] b0, input logic [7:0] b1);
    logic [127:0] r;
    case (n)
      2'd1:    r = {t[119:0], b0};
      2'd2:    r = {t[111:0], b0, b1};
      default: r = t;
    endcase
    return r;
  endfunction

endpackage

### src/ipp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_core
// Parse state registers and the per-character update for dotted quad and
// hex group text.
// ----------------------------------------------------------------------------
module ipp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                family_i,
  output ipp_pkg::ipp_state_t state_o
);
  import ipp_pkg::*;

  ipp_state_t st_q, st_d, nxt;
  logic [7:0]  lc;
  logic        is_dig, is_hexl, skip;
  logic [3:0]  dig_val, let_val, nib, lead;
  logic [11:0] oct_sum;
  logic [9:0]  dec;
  logic [1:0]  n_put;
  logic [7:0]  b0, b1;

  always_comb begin
    lc = char_i;
    if (char_i >= CHAR_UC_A && char_i <= CHAR_UC_Z) lc = char_i | CASE_BIT;
    is_dig  = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
    is_hexl = (lc >= CHAR_LC_A) && (lc <= CHAR_LC_F);
    dig_val = 4'(char_i - CHAR_ZERO);
    let_val = 4'(lc - CHAR_LC_A + 8'd10);
    nib     = is_dig ? dig_val : let_val;
    oct_sum = 12'(st_q.ov) * 12'd10 + 12'(dig_val);
    dec     = 10'(st_q.gv[11:8]) * 10'd100 + 10'(st_q.gv[7:4]) * 10'd10
              + 10'(st_q.gv[3:0]);
    case (st_q.tdc)
      3'd2:    lead = st_q.gv[7:4];
      3'd3:    lead = st_q.gv[11:8];
      3'd4:    lead = st_q.gv[15:12];
      default: lead = 4'hf;
    endcase
  end

  always_comb begin
    nxt   = st_q;
    n_put = 2'd0;
    b0    = 8'd0;
    b1    = 8'd0;
    skip  = 1'b0;
    if (!st_q.err) begin
      if (!family_i || st_q.in_tail) begin
        if (is_dig) begin
          if ((st_q.ds && st_q.ov == 8'd0) || oct_sum > OCTET_MAX) begin
            nxt.err = 1'b1;
          end else begin
            nxt.ov = oct_sum[7:0];
            if (!st_q.ds) begin
              if (st_q.oc >= MAX_OCTETS) begin
                nxt.err = 1'b1;
              end else begin
                nxt.oc = st_q.oc + 3'd1;
                nxt.ds = 1'b1;
              end
            end
          end
        end else if (char_i == CHAR_DOT && st_q.ds) begin
          if (st_q.oc >= MAX_OCTETS) begin
            nxt.err = 1'b1;
          end else begin
            n_put  = 2'd1;
            b0     = st_q.ov;
            nxt.ov = 8'd0;
            nxt.ds = 1'b0;
          end
        end else begin
          nxt.err = 1'b1;
        end
      end else begin
        if (st_q.cp == POS_START) begin
          nxt.cp = POS_BODY;
          if (char_i == CHAR_COLON) begin
            nxt.cp = POS_COLON;
            skip   = 1'b1;
          end
        end else if (st_q.cp == POS_COLON) begin
          nxt.cp = POS_BODY;
          if (char_i != CHAR_COLON) begin
            nxt.err = 1'b1;
            skip    = 1'b1;
          end
        end
        if (!skip) begin
          nxt.cjcg = 1'b0;
          if (is_dig || is_hexl) begin
            if (st_q.tdc >= MAX_DIGITS || st_q.gv > GROUP_LIMIT) begin
              nxt.err = 1'b1;
            end else begin
              if (!is_dig) nxt.letter = 1'b1;
              nxt.gv  = {st_q.gv[11:0], nib};
              nxt.tdc = st_q.tdc + 3'd1;
              nxt.ds  = 1'b1;
            end
          end else if (lc == CHAR_COLON) begin
            if (!st_q.ds) begin
              if (st_q.gap_seen) begin
                nxt.err = 1'b1;
              end else begin
                nxt.gap_seen = 1'b1;
                nxt.gp       = st_q.wp;
              end
            end else if (st_q.wp > PAIR_LIMIT) begin
              nxt.err = 1'b1;
            end else begin
              n_put      = 2'd2;
              b0         = st_q.gv[15:8];
              b1         = st_q.gv[7:0];
              nxt.gv     = 16'd0;
              nxt.ds     = 1'b0;
              nxt.tdc    = 3'd0;
              nxt.letter = 1'b0;
              nxt.cjcg   = 1'b1;
            end
          end else if (lc == CHAR_DOT) begin
            if (st_q.wp > TAIL_LIMIT || st_q.tdc == 3'd0 || st_q.letter ||
                lead == 4'd0 || st_q.gv[15:12] != 4'd0 || dec > DEC_MAX) begin
              nxt.err = 1'b1;
            end else begin
              n_put       = 2'd1;
              b0          = dec[7:0];
              nxt.gv      = 16'd0;
              nxt.ds      = 1'b0;
              nxt.tdc     = 3'd0;
              nxt.letter  = 1'b0;
              nxt.ov      = 8'd0;
              nxt.oc      = 3'd1;
              nxt.in_tail = 1'b1;
            end
          end else begin
            nxt.err = 1'b1;
          end
        end
      end
    end
    if (n_put != 2'd0) begin
      if (st_q.wp >= BYTES_END) begin
        nxt.err = 1'b1;
      end else begin
        if (st_q.gap_seen) nxt.tail = tail_put(st_q.tail, n_put, b0, b1);
        else nxt.head = head_put(st_q.head, st_q.wp, n_put, b0, b1);
        nxt.wp = st_q.wp + 5'(n_put);
      end
    end
  end

  always_comb begin
    st_d = st_q;
    if (clear_i) st_d = '0;
    else if (step_i) st_d = nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

### src/ipp_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_finish
// End-of-text check: closes the open group or octet, validates the byte
// count and merges head and tail bytes around the gap.
// ----------------------------------------------------------------------------
module ipp_finish (
  input  ipp_pkg::ipp_state_t state_i,
  input  logic                family_i,
  output logic                ok_o,
  output logic [63:0]         high_o,
  output logic [63:0]         low_o
);
  import ipp_pkg::*;

  logic         ok;
  logic [1:0]   n_put;
  logic [7:0]   b0, b1;
  logic [4:0]   wpf;
  logic [127:0] head_f, tail_f, addr;

  always_comb begin
    ok    = 1'b1;
    n_put = 2'd0;
    b0    = 8'd0;
    b1    = 8'd0;
    if (state_i.err) begin
      ok = 1'b0;
    end else if (!family_i) begin
      if (state_i.oc < MAX_OCTETS) ok = 1'b0;
      n_put = 2'd1;
      b0    = state_i.ov;
    end else begin
      if (state_i.cp == POS_COLON || state_i.cjcg) ok = 1'b0;
      if (state_i.in_tail) begin
        if (state_i.oc < MAX_OCTETS) ok = 1'b0;
        n_put = 2'd1;
        b0    = state_i.ov;
      end else if (state_i.ds) begin
        if (state_i.wp > PAIR_LIMIT) ok = 1'b0;
        n_put = 2'd2;
        b0    = state_i.gv[15:8];
        b1    = state_i.gv[7:0];
      end
    end
    if (n_put != 2'd0 && state_i.wp >= BYTES_END) ok = 1'b0;
    wpf    = state_i.wp + 5'(n_put);
    head_f = state_i.gap_seen ? state_i.head : head_put(state_i.head, state_i.wp, n_put, b0, b1);
    tail_f = state_i.gap_seen ? tail_put(state_i.tail, n_put, b0, b1) : state_i.tail;
    if (family_i) begin
      if (state_i.gap_seen) begin
        if (wpf == BYTES_END || state_i.gp > wpf) ok = 1'b0;
      end else if (wpf != BYTES_END) begin
        ok = 1'b0;
      end
    end
    addr = state_i.gap_seen ? (head_f | tail_f) : head_f;
  end

  assign ok_o   = ok;
  assign high_o = (ok && family_i) ? addr[127:64] : 64'd0;
  assign low_o  = !ok ? 64'd0 : (family_i ? addr[63:0] : {32'd0, head_f[127:96]});

endmodule

### src/ip_address_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Streams address text one character per transaction and, on NUL, returns
// the parsed IPv4 or IPv6 address with a well-formed flag.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   char_code_i
//   result   out        out_valid_o / out_ready_i valid_res_o, address_high_o,
//                                                 address_low_o
//   config   in         APB psel/penable/pwrite   address_family at 0x0
//
// One character per cycle while no stall holds the input; a character is
// parsed the cycle after it is taken into the input register, and a NUL
// moves its result into the result register once that register is free.
// The input stalls only while a NUL waits behind an untaken result.
// Reset is asynchronous, active low, and clears the parse state and family.
// ----------------------------------------------------------------------------
module ip_address_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [63:0] address_high_o,
  output logic [63:0] address_low_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ipp_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  char_q, char_d;
  logic        family_q, family_d;
  logic        out_valid_q, out_valid_d;
  logic        res_ok_q, res_ok_d;
  logic [63:0] res_high_q, res_high_d;
  logic [63:0] res_low_q, res_low_d;
  logic        cfg_wr, is_nul, adv, fin_ok;
  logic [63:0] fin_high, fin_low;
  ipp_state_t  state;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ADDRESS_FAMILY);
  assign prdata = (paddr[2] == REG_ADDRESS_FAMILY) ? {31'd0, family_q} : 32'd0;

  assign is_nul     = (char_q == CHAR_NUL);
  assign adv        = in_valid_q && (!is_nul || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  ipp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_wr || (adv && is_nul)),
    .step_i   (adv && !is_nul),
    .char_i   (char_q),
    .family_i (family_q),
    .state_o  (state)
  );

  ipp_finish u_finish (
    .state_i  (state),
    .family_i (family_q),
    .ok_o     (fin_ok),
    .high_o   (fin_high),
    .low_o    (fin_low)
  );

  always_comb begin
    family_d    = cfg_wr ? pwdata[0] : family_q;
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    char_d      = (in_ready_o && in_valid_i) ? char_code_i : char_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_ok_d    = res_ok_q;
    res_high_d  = res_high_q;
    res_low_d   = res_low_q;
    if (adv && is_nul) begin
      out_valid_d = 1'b1;
      res_ok_d    = fin_ok;
      res_high_d  = fin_high;
      res_low_d   = fin_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q    <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      family_q    <= family_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    res_ok_q   <= res_ok_d;
    res_high_q <= res_high_d;
    res_low_q  <= res_low_d;
  end

  assign out_valid_o    = out_valid_q;
  assign valid_res_o    = res_ok_q;
  assign address_high_o = res_high_q;
  assign address_low_o  = res_low_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> address_high_o == 64'd0 && address_low_o == 64'd0)
    else $error("invalid result carries a nonzero address");

  a_v4_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !family_q |-> address_high_o == 64'd0 && address_low_o[63:32] == 32'd0)
    else $error("IPv4 result outside bits 31..0");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.wp <= BYTES_END && state.gp <= state.wp)
    else $error("write or gap position out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && is_nul && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked NUL");

endmodule

### sim/tb_ip_address_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_address_text_parser
// Feeds address text one character per transaction and checks each result
// against an in-bench parse model or, for directed texts marked known, the
// table's entry. Directed texts cover both families, field extremes and the
// error paths; random well-formed, mutated and noise texts follow, with
// random idling on both channels and family changes over APB between texts.
// ----------------------------------------------------------------------------
module tb_ip_address_text_parser;
  import ipp_pkg::*;

  localparam logic FAM_IPV4 = 1'b0;
  localparam logic FAM_IPV6 = 1'b1;
  localparam int   NUM_DIR = 27;
  localparam int   RANDOM_CHARS = 860;

  typedef struct packed {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  typedef struct {
    logic         fam;
    string        text;
    logic         drop;
    logic         known;
    addr_result_t want;
  } text_case_t;

  localparam addr_result_t NO_ADDRESS   = '{ok: 1'b0, hi: 64'h0, lo: 64'h0};
  localparam addr_result_t ZERO_ADDRESS = '{ok: 1'b1, hi: 64'h0, lo: 64'h0};
  localparam addr_result_t ONES_V6      = '{ok: 1'b1, hi: '1, lo: '1};
  localparam addr_result_t ONES_V4      = '{ok: 1'b1, hi: 64'h0, lo: 64'hffff_ffff};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [63:0] address_high_o;
  logic [63:0] address_low_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ip_address_text_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .valid_res_o    (valid_res_o),
    .address_high_o (address_high_o),
    .address_low_o  (address_low_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  text_case_t dir_cases [NUM_DIR] = '{
    '{FAM_IPV4, "",                                        1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "0.0.0.0",                                 1'b0, 1'b1, ZERO_ADDRESS},
    '{FAM_IPV4, "255.255.255.255",                         1'b0, 1'b1, ONES_V4},
    '{FAM_IPV4, "256.1.1.1",                               1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "01.2.3.4",                                1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "1.2.3",                                   1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "1.2.3.4.5",                               1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "1.2.3.\377",                              1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "192.168.1.10",                            1'b0, 1'b0, NO_ADDRESS},
    '{FAM_IPV4, "10.20",                                   1'b1, 1'b0, NO_ADDRESS},
    '{FAM_IPV4, "9.8.7.6",                                 1'b0, 1'b0, NO_ADDRESS},
    '{FAM_IPV6, "",                                        1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "::",                                      1'b0, 1'b1, ZERO_ADDRESS},
    '{FAM_IPV6, "ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", 1'b0, 1'b1, ONES_V6},
    '{FAM_IPV6, "12345::",                                 1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, ":1::",                                    1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "1:2:3:4:5:6:7:",                          1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "1::2::3",                                 1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "1:2:3:4:5:6:7:8:9",                       1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "1:2:3:4:5:6:7:8::",                       1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "::ffff:192.168.1.1",                      1'b0, 1'b0, NO_ADDRESS},
    '{FAM_IPV6, "1:2:3:4:5:6:7:1.2.3.4",                   1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "::1.2.3",                                 1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV6, "aBcD:E::1",                               1'b0, 1'b0, NO_ADDRESS},
    '{FAM_IPV6, "1:2",                                     1'b1, 1'b0, NO_ADDRESS},
    '{FAM_IPV6, "::\377",                                  1'b0, 1'b1, NO_ADDRESS},
    '{FAM_IPV4, "127.0.0.1",                               1'b0, 1'b0, NO_ADDRESS}
  };

  addr_result_t pending_addr_q [$];
  logic [7:0]   txt_buf [$];
  int           mismatch_count = 0;
  int           chars_sent = 0;
  logic         idle_en = 1'b1;
  addr_result_t got_want;

  logic         fam_cur = FAM_IPV4;
  logic [7:0]   addr_bytes [NUM_BYTES];
  logic [4:0]   wr_pos;
  logic [4:0]   gap_pos;
  logic         gap_hit;
  logic [15:0]  grp_val;
  logic         dig_seen;
  logic [2:0]   hex_cnt;
  logic         hex_letter;
  logic         in_tail;
  logic [7:0]   oct_val;
  logic [2:0]   oct_cnt;
  logic         text_err;
  logic [1:0]   text_pos;
  logic         colon_closed;

  function automatic void clear_parse();
    foreach (addr_bytes[i]) addr_bytes[i] = 8'h00;
    wr_pos = '0;
    gap_pos = '0;
    gap_hit = 1'b0;
    grp_val = '0;
    dig_seen = 1'b0;
    hex_cnt = '0;
    hex_letter = 1'b0;
    in_tail = 1'b0;
    oct_val = '0;
    oct_cnt = '0;
    text_err = 1'b0;
    text_pos = POS_START;
    colon_closed = 1'b0;
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    if (wr_pos < BYTES_END) begin
      addr_bytes[wr_pos[3:0]] = v;
      wr_pos = wr_pos + 5'd1;
    end else begin
      text_err = 1'b1;
    end
  endfunction

  function automatic void reset_group();
    grp_val = '0;
    dig_seen = 1'b0;
    hex_cnt = '0;
    hex_letter = 1'b0;
  endfunction

  function automatic void quad_step(input logic [7:0] c);
    int unsigned n;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      n = int'(oct_val) * 10 + int'(c) - int'(CHAR_ZERO);
      if (dig_seen && oct_val == 8'd0) begin
        text_err = 1'b1;
        return;
      end
      if (n > 255) begin
        text_err = 1'b1;
        return;
      end
      oct_val = n[7:0];
      if (!dig_seen) begin
        if (oct_cnt >= MAX_OCTETS) begin
          text_err = 1'b1;
          return;
        end
        oct_cnt = oct_cnt + 3'd1;
        dig_seen = 1'b1;
      end
    end else if (c == CHAR_DOT && dig_seen) begin
      if (oct_cnt >= MAX_OCTETS) begin
        text_err = 1'b1;
        return;
      end
      put_byte(oct_val);
      oct_val = '0;
      dig_seen = 1'b0;
    end else begin
      text_err = 1'b1;
    end
  endfunction

  function automatic void hex_step(input logic [7:0] c);
    logic [7:0]  lc;
    logic [3:0]  d;
    int unsigned dec;
    int          k;
    if (in_tail) begin
      quad_step(c);
      return;
    end
    if (text_pos == POS_START) begin
      text_pos = POS_BODY;
      if (c == CHAR_COLON) begin
        text_pos = POS_COLON;
        return;
      end
    end else if (text_pos == POS_COLON) begin
      text_pos = POS_BODY;
      if (c != CHAR_COLON) begin
        text_err = 1'b1;
        return;
      end
    end
    colon_closed = 1'b0;
    lc = (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? (c | CASE_BIT) : c;
    if ((lc >= CHAR_ZERO && lc <= CHAR_NINE) || (lc >= CHAR_LC_A && lc <= CHAR_LC_F)) begin
      d = (lc <= CHAR_NINE) ? 4'(lc - CHAR_ZERO) : 4'(lc - CHAR_LC_A + 8'd10);
      if (hex_cnt >= MAX_DIGITS || grp_val > GROUP_LIMIT) begin
        text_err = 1'b1;
        return;
      end
      if (d > 4'd9) hex_letter = 1'b1;
      grp_val = {grp_val[11:0], d};
      hex_cnt = hex_cnt + 3'd1;
      dig_seen = 1'b1;
    end else if (lc == CHAR_COLON) begin
      if (!dig_seen) begin
        if (gap_hit) begin
          text_err = 1'b1;
          return;
        end
        gap_hit = 1'b1;
        gap_pos = wr_pos;
        return;
      end
      if (wr_pos > PAIR_LIMIT) begin
        text_err = 1'b1;
        return;
      end
      put_byte(grp_val[15:8]);
      put_byte(grp_val[7:0]);
      reset_group();
      colon_closed = 1'b1;
    end else if (lc == CHAR_DOT) begin
      if (wr_pos > TAIL_LIMIT || hex_cnt == 3'd0 || hex_letter) begin
        text_err = 1'b1;
        return;
      end
      if (hex_cnt > 3'd1 && grp_val[4*(int'(hex_cnt)-1) +: 4] == 4'd0) begin
        text_err = 1'b1;
        return;
      end
      dec = 0;
      for (k = int'(hex_cnt); k > 0; k--) dec = dec * 10 + grp_val[4*(k-1) +: 4];
      if (dec > 255) begin
        text_err = 1'b1;
        return;
      end
      put_byte(dec[7:0]);
      reset_group();
      oct_val = '0;
      oct_cnt = 3'd1;
      in_tail = 1'b1;
    end else begin
      text_err = 1'b1;
    end
  endfunction

  function automatic addr_result_t close_text();
    addr_result_t r;
    logic [7:0]   ob [NUM_BYTES];
    int           n;
    r = NO_ADDRESS;
    foreach (ob[i]) ob[i] = 8'h00;
    if (text_err) return r;
    if (fam_cur == FAM_IPV4) begin
      if (oct_cnt < MAX_OCTETS) return r;
      put_byte(oct_val);
      r.ok = 1'b1;
      r.lo = {32'h0, addr_bytes[0], addr_bytes[1], addr_bytes[2], addr_bytes[3]};
      return r;
    end
    if (text_pos == POS_COLON || colon_closed) return r;
    if (in_tail) begin
      if (oct_cnt < MAX_OCTETS) return r;
      put_byte(oct_val);
    end else if (dig_seen) begin
      if (wr_pos > PAIR_LIMIT) return r;
      put_byte(grp_val[15:8]);
      put_byte(grp_val[7:0]);
    end
    if (text_err || wr_pos > BYTES_END) return r;
    if (gap_hit) begin
      if (wr_pos == BYTES_END || gap_pos > wr_pos) return r;
      n = int'(wr_pos) - int'(gap_pos);
      for (int i = 0; i < int'(gap_pos); i++) ob[i] = addr_bytes[i];
      for (int i = 0; i < n; i++) ob[NUM_BYTES - n + i] = addr_bytes[(int'(gap_pos) + i) % 16];
    end else begin
      if (wr_pos != BYTES_END) return r;
      foreach (ob[i]) ob[i] = addr_bytes[i];
    end
    r.ok = 1'b1;
    for (int i = 0; i < 8; i++) r.hi = {r.hi[55:0], ob[i]};
    for (int i = 8; i < 16; i++) r.lo = {r.lo[55:0], ob[i]};
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] e,
                                      input logic [63:0] a);
    if (e !== a) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
    end
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 5))
      0:       return CHAR_COLON;
      1:       return CHAR_DOT;
      2:       return CHAR_ZERO;
      3:       return CHAR_ZERO + 8'($urandom_range(0, 9));
      4:       return CHAR_UC_A + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void add_quad();
    int unsigned v;
    for (int i = 0; i < 4; i++) begin
      if (i != 0) txt_buf.push_back(CHAR_DOT);
      case ($urandom_range(0, 5))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(0, 9);
        default: v = $urandom_range(0, 255);
      endcase
      if (v >= 100) txt_buf.push_back(CHAR_ZERO + 8'(v / 100));
      if (v >= 10) txt_buf.push_back(CHAR_ZERO + 8'((v / 10) % 10));
      txt_buf.push_back(CHAR_ZERO + 8'(v % 10));
    end
  endfunction

  function automatic void add_groups(input int unsigned cnt);
    int unsigned d;
    for (int unsigned g = 0; g < cnt; g++) begin
      if (g != 0) txt_buf.push_back(CHAR_COLON);
      repeat ($urandom_range(1, 4)) begin
        d = $urandom_range(0, 15);
        if (d < 10) txt_buf.push_back(CHAR_ZERO + 8'(d));
        else if ($urandom_range(0, 1) == 0) txt_buf.push_back(CHAR_LC_A + 8'(d - 10));
        else txt_buf.push_back(CHAR_UC_A + 8'(d - 10));
      end
    end
  endfunction

  function automatic void build_text(input logic f);
    int unsigned sel, slots, n, left, pos;
    logic        tail;
    txt_buf.delete();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(0, 12)) txt_buf.push_back(8'($urandom_range(1, 255)));
      return;
    end
    if (f == FAM_IPV4) begin
      add_quad();
    end else begin
      tail = ($urandom_range(0, 99) < 30);
      slots = tail ? 6 : 8;
      if ($urandom_range(0, 99) < 70) begin
        n = $urandom_range(0, slots);
        left = $urandom_range(0, n);
        add_groups(left);
        txt_buf.push_back(CHAR_COLON);
        txt_buf.push_back(CHAR_COLON);
        add_groups(n - left);
        if (tail && n > left) txt_buf.push_back(CHAR_COLON);
      end else begin
        add_groups(slots);
        if (tail) txt_buf.push_back(CHAR_COLON);
      end
      if (tail) add_quad();
    end
    if (sel < 33 && txt_buf.size() > 0) begin
      pos = $urandom_range(0, txt_buf.size() - 1);
      case ($urandom_range(0, 3))
        0:       txt_buf[pos] = odd_char();
        1:       txt_buf.insert(pos, odd_char());
        2:       txt_buf.delete(pos);
        default: while (txt_buf.size() > pos) txt_buf.delete(txt_buf.size() - 1);
      endcase
    end
  endfunction

  function automatic void accept_char(input logic [7:0] c, input logic known,
                                      input addr_result_t want);
    addr_result_t r;
    if (c != CHAR_NUL) begin
      if (!text_err) begin
        if (fam_cur == FAM_IPV6) hex_step(c);
        else quad_step(c);
      end
    end else begin
      r = close_text();
      pending_addr_q.push_back(known ? want : r);
      clear_parse();
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic known, input addr_result_t want);
    while (idle_en && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
    accept_char(c, known, want);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_addr_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_family(input logic f);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_ADDRESS_FAMILY, 2'b00};
    pwdata <= {31'h0, f};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    fam_cur = f;
    clear_parse();
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("address_family readback", {63'h0, f}, {32'h0, prdata});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !idle_en || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_addr_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t unexpected result transaction", $realtime);
      end else begin
        got_want = pending_addr_q.pop_front();
        check_field("valid_res", {63'h0, got_want.ok}, {63'h0, valid_res_o});
        check_field("address_high", got_want.hi, address_high_o);
        check_field("address_low", got_want.lo, address_low_o);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("ip_address_text_parser verification failed");
    $finish;
  end

  initial begin
    bit paused;
    paused = 1'b0;
    clear_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_cases[r].fam != fam_cur) begin
        settle();
        write_family(dir_cases[r].fam);
      end
      for (int i = 0; i < dir_cases[r].text.len(); i++)
        send_char(dir_cases[r].text[i], 1'b0, NO_ADDRESS);
      if (dir_cases[r].drop) begin
        settle();
        write_family(fam_cur);
      end else begin
        send_char(CHAR_NUL, dir_cases[r].known, dir_cases[r].want);
      end
    end

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      idle_en = !(chars_sent >= 340 && chars_sent < 490);
      if (!paused && chars_sent >= 600) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 12) begin
        settle();
        write_family(1'($urandom_range(0, 1)));
      end
      build_text(fam_cur);
      if ($urandom_range(0, 99) < 4 && txt_buf.size() > 1) begin
        for (int i = 0; i < txt_buf.size() / 2; i++) send_char(txt_buf[i], 1'b0, NO_ADDRESS);
        settle();
        write_family(1'($urandom_range(0, 1)));
      end else begin
        for (int i = 0; i < txt_buf.size(); i++) send_char(txt_buf[i], 1'b0, NO_ADDRESS);
        send_char(CHAR_NUL, 1'b0, NO_ADDRESS);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_addr_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_addr_q.size() == 0) begin
      $display("ip_address_text_parser verification clean");
    end else begin
      $display("ip_address_text_parser verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/ipp_pkg.sv
src/ipp_core.sv
src/ipp_finish.sv
src/ip_address_text_parser.sv
sim/tb_ip_address_text_parser.sv
